[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent checks, clocked on clk and idle in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[hdl/tofts_pkg.sv]
// ----------------------------------------------------------------------------
// tofts_pkg
// types and constants shared by the time-of-flight target selector
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tofts_pkg;

    localparam int DIST_W   = 16;
    localparam int CONF_W   = 16;
    localparam int CHAN_W   = 8;
    localparam int SLOT_W   = 4;
    localparam int SMOOTH_W = 24;
    localparam int GAIN_W   = 16;
    localparam int COUNT_W  = 7;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W   = GAIN_W + SMOOTH_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_CONF   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 2'd3;

    // register reset values
    localparam logic [CFG_W-1:0] NEAR_LIMIT_RST = 16'd80;
    localparam logic [CFG_W-1:0] FAR_LIMIT_RST  = 16'd5000;
    localparam logic [CFG_W-1:0] MIN_CONF_RST   = 16'd20;
    localparam logic [CFG_W-1:0] GAIN_RST       = 16'd22938;

    // half an lsb of the q0.16 gain product
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

    typedef struct packed {
        logic              target_present;
        logic [DIST_W-1:0] range_mm;
        logic [CONF_W-1:0] confidence;
        logic [CHAN_W-1:0] channel;
        logic              last_item;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [DIST_W-1:0]   depth_mm;
        logic [CONF_W-1:0]   depth_confidence;
        logic [SMOOTH_W-1:0] smoothed_depth;
        logic                last_result;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic              load;
        logic              update;
        logic              mul;
        logic              adj;
        logic              out_load;
        logic              overall;
        logic              clear;
        logic [SLOT_W-1:0] slot;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic item_last;
    } dp_stat_t;

endpackage

`default_nettype wire

[hdl/tofts_dp.sv]
// ----------------------------------------------------------------------------
// tofts_dp
// datapath: limits, per-zone and overall nearest stores, smoothing, result reg
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tofts_dp #(
    parameter int ZONE_COUNT             = 9,
    parameter int MAX_TARGETS_PER_REPORT = 36
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_we,
    input  wire  [tofts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [tofts_pkg::CFG_W-1:0]        cfg_data,
    input  wire  tofts_pkg::in_item_t          in_data,
    input  wire  tofts_pkg::dp_cmd_t           cmd,
    output tofts_pkg::dp_stat_t                stat,
    output tofts_pkg::out_item_t               out_data
);

    localparam int ZW = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
    localparam logic [tofts_pkg::CHAN_W-1:0]  ZONE_LAST =
        tofts_pkg::CHAN_W'(ZONE_COUNT);
    localparam logic [tofts_pkg::COUNT_W-1:0] CAP =
        tofts_pkg::COUNT_W'(MAX_TARGETS_PER_REPORT);

    logic [tofts_pkg::CFG_W-1:0] near_reg;
    logic [tofts_pkg::CFG_W-1:0] far_reg;
    logic [tofts_pkg::CFG_W-1:0] minc_reg;
    logic [tofts_pkg::GAIN_W-1:0] gain_reg;

    tofts_pkg::in_item_t item_reg;

    logic [tofts_pkg::DIST_W-1:0] zmm_reg   [ZONE_COUNT];
    logic [tofts_pkg::CONF_W-1:0] zconf_reg [ZONE_COUNT];
    logic [ZONE_COUNT-1:0]        zvalid_reg;

    logic [tofts_pkg::DIST_W-1:0]   best_mm_reg;
    logic [tofts_pkg::CONF_W-1:0]   best_conf_reg;
    logic [tofts_pkg::SMOOTH_W-1:0] smooth_reg;
    logic [tofts_pkg::SMOOTH_W-1:0] smooth_next;
    logic [tofts_pkg::COUNT_W-1:0]  seen_reg;
    logic [tofts_pkg::PROD_W-1:0]   prod_reg;
    logic                           up_reg;

    tofts_pkg::out_item_t out_reg;
    tofts_pkg::out_item_t out_next;

    logic                           counted;
    logic                           keep;
    logic                           in_zone;
    logic [ZW-1:0]                  zidx;
    logic [ZW-1:0]                  rd_idx;
    logic                           rd_valid;
    logic [tofts_pkg::DIST_W-1:0]   rd_mm;
    logic [tofts_pkg::CONF_W-1:0]   rd_conf;
    logic                           zone_win;
    logic                           best_win;
    logic [tofts_pkg::SMOOTH_W-1:0] target_q8;
    logic                           up;
    logic [tofts_pkg::SMOOTH_W-1:0] diff;
    logic [tofts_pkg::PROD_W-1:0]   rounded;
    logic [tofts_pkg::SMOOTH_W-1:0] step;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_reg <= tofts_pkg::NEAR_LIMIT_RST;
            far_reg  <= tofts_pkg::FAR_LIMIT_RST;
            minc_reg <= tofts_pkg::MIN_CONF_RST;
            gain_reg <= tofts_pkg::GAIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tofts_pkg::REG_NEAR_LIMIT: near_reg <= cfg_data;
                tofts_pkg::REG_FAR_LIMIT:  far_reg  <= cfg_data;
                tofts_pkg::REG_MIN_CONF:   minc_reg <= cfg_data;
                tofts_pkg::REG_GAIN:       gain_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
    end

    assign stat.item_last = item_reg.last_item;

    // target qualification
    always_comb
    begin
        counted = item_reg.target_present && (seen_reg < CAP);
        keep    = counted
                  && (item_reg.range_mm != '0) && (item_reg.confidence != '0)
                  && (item_reg.range_mm >= near_reg)
                  && (item_reg.range_mm <= far_reg)
                  && (item_reg.confidence >= minc_reg);
        in_zone = (item_reg.channel >= tofts_pkg::CHAN_W'(1))
                  && (item_reg.channel <= ZONE_LAST);
        zidx    = ZW'(item_reg.channel - tofts_pkg::CHAN_W'(1));
        rd_idx  = cmd.update ? zidx : cmd.slot[ZW-1:0];
        rd_valid = zvalid_reg[rd_idx];
        rd_mm    = zmm_reg[rd_idx];
        rd_conf  = zconf_reg[rd_idx];
        zone_win = keep && in_zone && (!rd_valid || (item_reg.range_mm < rd_mm));
        best_win = keep && ((best_mm_reg == '0) || (item_reg.range_mm < best_mm_reg));
    end

    // zone stores, an entry without its valid bit reads as zero
    always_ff @(posedge clk)
    begin
        if (cmd.update && zone_win)
        begin
            zmm_reg[zidx]   <= item_reg.range_mm;
            zconf_reg[zidx] <= item_reg.confidence;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zvalid_reg    <= '0;
            best_mm_reg   <= '0;
            best_conf_reg <= '0;
            seen_reg      <= '0;
        end
        else if (cmd.clear)
        begin
            zvalid_reg    <= '0;
            best_mm_reg   <= '0;
            best_conf_reg <= '0;
            seen_reg      <= '0;
        end
        else if (cmd.update)
        begin
            if (counted)
            begin
                seen_reg <= seen_reg + tofts_pkg::COUNT_W'(1);
            end
            if (zone_win)
            begin
                zvalid_reg[zidx] <= 1'b1;
            end
            if (best_win)
            begin
                best_mm_reg   <= item_reg.range_mm;
                best_conf_reg <= item_reg.confidence;
            end
        end
    end

    // smoothing: gain times the gap to the target is registered, the rounded step is applied in the cycle after
    always_comb
    begin
        target_q8 = {best_mm_reg, 8'd0};
        up        = (target_q8 >= smooth_reg);
        diff      = up ? (target_q8 - smooth_reg) : (smooth_reg - target_q8);
        rounded   = prod_reg + tofts_pkg::ROUND_HALF;
        step      = rounded[tofts_pkg::PROD_W-1:16];
        if (best_mm_reg == '0)
        begin
            smooth_next = smooth_reg;
        end
        else if (smooth_reg == '0)
        begin
            smooth_next = target_q8;
        end
        else if (up_reg)
        begin
            smooth_next = smooth_reg + step;
        end
        else
        begin
            smooth_next = smooth_reg - step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= tofts_pkg::PROD_W'(gain_reg) * tofts_pkg::PROD_W'(diff);
            up_reg   <= up;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_reg <= '0;
        end
        else if (cmd.adj)
        begin
            smooth_reg <= smooth_next;
        end
    end

    // result register
    always_comb
    begin
        out_next.slot        = cmd.slot;
        out_next.last_result = cmd.overall;
        if (cmd.overall)
        begin
            out_next.depth_mm         = best_mm_reg;
            out_next.depth_confidence = best_conf_reg;
            out_next.smoothed_depth   = smooth_reg;
        end
        else
        begin
            out_next.depth_mm         = rd_valid ? rd_mm : '0;
            out_next.depth_confidence = rd_valid ? rd_conf : '0;
            out_next.smoothed_depth   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

[hdl/tofts_ctrl.sv]
// ----------------------------------------------------------------------------
// tofts_ctrl
// sequencer: request capture, store update, smoothing steps, result emission
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tofts_ctrl #(
    parameter int ZONE_COUNT = 9
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire                  out_ready,
    input  wire tofts_pkg::dp_stat_t stat,
    output tofts_pkg::dp_cmd_t   cmd
);

    localparam int CW = $clog2(ZONE_COUNT + 1);
    localparam logic [CW-1:0] LAST_CNT = CW'(ZONE_COUNT);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_UPDATE = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_ADJ    = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          emit_load;
    logic          overall;

    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        overall   = (cnt_reg == LAST_CNT);
        emit_load = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

        cmd.load     = in_valid && in_ready;
        cmd.update   = (state_reg == ST_UPDATE);
        cmd.mul      = (state_reg == ST_MUL);
        cmd.adj      = (state_reg == ST_ADJ);
        cmd.out_load = emit_load;
        cmd.overall  = overall;
        cmd.clear    = emit_load && overall;
        cmd.slot     = tofts_pkg::SLOT_W'(cnt_reg);

        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = stat.item_last ? ST_MUL : ST_IDLE;
            end
            ST_MUL:
            begin
                state_next = ST_ADJ;
            end
            ST_ADJ:
            begin
                state_next = ST_EMIT;
                cnt_next   = '0;
            end
            ST_EMIT:
            begin
                if (emit_load)
                begin
                    if (overall)
                    begin
                        state_next = ST_IDLE;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[hdl/tof_report_target_select.sv]
// ----------------------------------------------------------------------------
// tof_report_target_select
// picks the nearest target per zone and overall from each time-of-flight report
// ----------------------------------------------------------------------------
// A target request is captured in the idle state and then checked against the
// limits and compared with the zone and overall nearest registers in the update
// state. The request that ends a report goes on through the smoothing multiply
// and the rounded adjust, after which ZONE_COUNT + 1 results leave one per cycle
// while out_ready is high. The last result sits in the output register, so the
// next request is taken while it waits.
`timescale 1ns / 1ps
`default_nettype none

module tof_report_target_select #(
    parameter int ZONE_COUNT             = 9,
    parameter int MAX_TARGETS_PER_REPORT = 36
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_we,
    input  wire  [tofts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [tofts_pkg::CFG_W-1:0]       cfg_data,
    input  wire                               in_valid,
    output logic                              in_ready,
    input  wire  tofts_pkg::in_item_t         in_data,
    output logic                              out_valid,
    input  wire                               out_ready,
    output tofts_pkg::out_item_t              out_data
);

    tofts_pkg::dp_cmd_t  cmd;
    tofts_pkg::dp_stat_t stat;

    tofts_ctrl #(
        .ZONE_COUNT (ZONE_COUNT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tofts_dp #(
        .ZONE_COUNT             (ZONE_COUNT),
        .MAX_TARGETS_PER_REPORT (MAX_TARGETS_PER_REPORT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

[hdl/tofts_checker.sv]
// ----------------------------------------------------------------------------
// tofts_checker
// port-level checks on the target selector, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tofts_checker #(
    parameter int ZONE_COUNT = 9
) (
    input wire                       clk,
    input wire                       rst_n,
    input wire                       in_valid,
    input wire                       in_ready,
    input wire                       out_valid,
    input wire                       out_ready,
    input wire tofts_pkg::out_item_t out_data
);

    localparam logic [tofts_pkg::SLOT_W-1:0] SLOT_OVERALL =
        tofts_pkg::SLOT_W'(ZONE_COUNT);

    // a stalled result keeps its contents
    `ASSERT_CLK(a_out_hold,
        (out_valid && !out_ready |=> out_valid && $stable(out_data)),
        "result changed while stalled")

    // in_ready drops after every accepted request
    `ASSERT_CLK(a_in_gap, (in_valid && in_ready |=> !in_ready),
        "request taken on back-to-back cycles")

    // the overall result always carries the overall slot
    `ASSERT_CLK(a_overall_slot,
        (out_valid && out_data.last_result |-> out_data.slot == SLOT_OVERALL),
        "overall result on wrong slot")

    // zone results carry no smoothed depth
    `ASSERT_NEVER(a_zone_smooth,
        (out_valid && !out_data.last_result && out_data.smoothed_depth != '0),
        "zone result with smoothed depth")

endmodule

bind tof_report_target_select tofts_checker #(
    .ZONE_COUNT (ZONE_COUNT)
) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

[tb/tb_tof_report_target_select.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tof_report_target_select
// Drives time-of-flight reports as runs of target requests through the
// target selector. Every accepted request updates a local copy of the zone
// and overall nearest stores and the smoothed depth. Each report end queues
// nine zone results and one overall result, which are checked in order
// against what the block returns. Reports come under several register
// settings, extremes included, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_tof_report_target_select;

    localparam int ZONES          = 9;
    localparam int TARGET_CAP     = 36;
    localparam int TOTAL_ITEMS    = 400;
    localparam int PHASE_ITEMS    = 52;
    localparam int SETTLE_CYCLES  = 12;
    localparam int CYCLE_LIMIT    = 100000;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [tofts_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [tofts_pkg::CFG_W-1:0]     cfg_data  = '0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    tofts_pkg::in_item_t             in_data   = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    tofts_pkg::out_item_t            out_data;

    // local copy of the registers
    logic [tofts_pkg::CFG_W-1:0] near_mm    = tofts_pkg::NEAR_LIMIT_RST;
    logic [tofts_pkg::CFG_W-1:0] far_mm     = tofts_pkg::FAR_LIMIT_RST;
    logic [tofts_pkg::CFG_W-1:0] conf_floor = tofts_pkg::MIN_CONF_RST;
    logic [tofts_pkg::CFG_W-1:0] gain       = tofts_pkg::GAIN_RST;

    // local copy of the report stores
    logic [tofts_pkg::DIST_W-1:0]   zone_mm [ZONES];
    logic [tofts_pkg::CONF_W-1:0]   zone_conf [ZONES];
    logic [tofts_pkg::DIST_W-1:0]   nearest_mm;
    logic [tofts_pkg::CONF_W-1:0]   nearest_conf;
    logic [tofts_pkg::SMOOTH_W-1:0] smooth_q8 = '0;
    int unsigned                    targets_counted;

    tofts_pkg::in_item_t  pending_requests[$];
    tofts_pkg::out_item_t expected_results[$];
    int unsigned items_queued = 0;
    int unsigned error_count  = 0;
    int unsigned cycle_count  = 0;
    logic        steady       = 1'b0;

    tof_report_target_select #(
        .ZONE_COUNT             (ZONES),
        .MAX_TARGETS_PER_REPORT (TARGET_CAP)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic void clear_report_state();
        for (int z = 0; z < ZONES; z++)
        begin
            zone_mm[z]   = '0;
            zone_conf[z] = '0;
        end
        nearest_mm      = '0;
        nearest_conf    = '0;
        targets_counted = 0;
    endfunction

    function automatic logic [tofts_pkg::SMOOTH_W-1:0] smooth_toward(
        input logic [tofts_pkg::SMOOTH_W-1:0] acc,
        input logic [tofts_pkg::DIST_W-1:0]   mm);
        logic [tofts_pkg::SMOOTH_W-1:0] goal;
        logic [tofts_pkg::PROD_W-1:0]   step;
        goal = {mm, 8'd0};
        if (acc == '0)
            return goal;
        if (goal >= acc)
        begin
            step = (tofts_pkg::PROD_W'(gain) * tofts_pkg::PROD_W'(goal - acc)
                    + tofts_pkg::ROUND_HALF) >> 16;
            return acc + tofts_pkg::SMOOTH_W'(step);
        end
        step = (tofts_pkg::PROD_W'(gain) * tofts_pkg::PROD_W'(acc - goal)
                + tofts_pkg::ROUND_HALF) >> 16;
        return acc - tofts_pkg::SMOOTH_W'(step);
    endfunction

    task automatic select_targets(input tofts_pkg::in_item_t req);
        tofts_pkg::out_item_t res;
        int                   z;
        if (req.target_present && targets_counted < TARGET_CAP)
        begin
            targets_counted++;
            if (req.range_mm != '0 && req.confidence != '0 &&
                req.range_mm >= near_mm && req.range_mm <= far_mm &&
                req.confidence >= conf_floor)
            begin
                if (req.channel >= 1 && req.channel <= ZONES)
                begin
                    z = int'(req.channel) - 1;
                    if (zone_mm[z] == '0 || req.range_mm < zone_mm[z])
                    begin
                        zone_mm[z]   = req.range_mm;
                        zone_conf[z] = req.confidence;
                    end
                end
                if (nearest_mm == '0 || req.range_mm < nearest_mm)
                begin
                    nearest_mm   = req.range_mm;
                    nearest_conf = req.confidence;
                end
            end
        end
        if (req.last_item)
        begin
            if (nearest_mm != '0)
                smooth_q8 = smooth_toward(smooth_q8, nearest_mm);
            for (z = 0; z < ZONES; z++)
            begin
                res.slot             = tofts_pkg::SLOT_W'(z);
                res.depth_mm         = zone_mm[z];
                res.depth_confidence = zone_conf[z];
                res.smoothed_depth   = '0;
                res.last_result      = 1'b0;
                expected_results.push_back(res);
            end
            res.slot             = tofts_pkg::SLOT_W'(ZONES);
            res.depth_mm         = nearest_mm;
            res.depth_confidence = nearest_conf;
            res.smoothed_depth   = smooth_q8;
            res.last_result      = 1'b1;
            expected_results.push_back(res);
            clear_report_state();
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        error_count++;
    endtask

    task automatic check_result(input tofts_pkg::out_item_t got);
        tofts_pkg::out_item_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing expected, slot %0d depth %0d",
                                      got.slot, got.depth_mm));
            return;
        end
        want = expected_results.pop_front();
        if (got.slot !== want.slot)
            report_mismatch($sformatf("slot %0d, expected %0d", got.slot, want.slot));
        if (got.depth_mm !== want.depth_mm)
            report_mismatch($sformatf("slot %0d depth %0d, expected %0d",
                                      want.slot, got.depth_mm, want.depth_mm));
        if (got.depth_confidence !== want.depth_confidence)
            report_mismatch($sformatf("slot %0d confidence %0d, expected %0d",
                                      want.slot, got.depth_confidence,
                                      want.depth_confidence));
        if (got.smoothed_depth !== want.smoothed_depth)
            report_mismatch($sformatf("slot %0d smoothed %0d, expected %0d",
                                      want.slot, got.smoothed_depth, want.smoothed_depth));
        if (got.last_result !== want.last_result)
            report_mismatch($sformatf("slot %0d last flag %0b, expected %0b",
                                      want.slot, got.last_result, want.last_result));
    endtask

    // sender: a new request goes out once the current one has been taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (pending_requests.size() != 0 && (steady || $urandom_range(99) >= 7))
            begin
                in_valid <= 1'b1;
                in_data  <= pending_requests.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= steady || ($urandom_range(99) >= 7);
    end

    // results are checked before the request taken at the same edge is predicted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_result(out_data);
            if (in_valid && in_ready)
                select_targets(in_data);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[tof_report_target_select] ERROR");
            $finish;
        end
    end

    task automatic queue_request(input logic present,
                                 input logic [tofts_pkg::DIST_W-1:0] mm,
                                 input logic [tofts_pkg::CONF_W-1:0] conf,
                                 input logic [tofts_pkg::CHAN_W-1:0] ch,
                                 input logic last);
        tofts_pkg::in_item_t req;
        req.target_present = present;
        req.range_mm       = mm;
        req.confidence     = conf;
        req.channel        = ch;
        req.last_item      = last;
        pending_requests.push_back(req);
        items_queued++;
    endtask

    task automatic write_reg(input logic [tofts_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tofts_pkg::CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            tofts_pkg::REG_NEAR_LIMIT: near_mm    = value;
            tofts_pkg::REG_FAR_LIMIT:  far_mm     = value;
            tofts_pkg::REG_MIN_CONF:   conf_floor = value;
            tofts_pkg::REG_GAIN:       gain       = value;
            default: ;
        endcase
    endtask

    task automatic wait_for_drain();
        while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mostly inside the window, with zeros, edges and wild values mixed in
    function automatic logic [tofts_pkg::DIST_W-1:0] pick_distance();
        int unsigned roll = $urandom_range(99);
        if (roll < 8)
            return '0;
        if (roll < 18)
            return tofts_pkg::DIST_W'($urandom);
        if (roll < 26)
            return near_mm + tofts_pkg::DIST_W'($urandom_range(2)) - tofts_pkg::DIST_W'(1);
        if (roll < 34)
            return far_mm + tofts_pkg::DIST_W'($urandom_range(2)) - tofts_pkg::DIST_W'(1);
        if (near_mm <= far_mm)
            return tofts_pkg::DIST_W'($urandom_range(far_mm, near_mm));
        return tofts_pkg::DIST_W'($urandom);
    endfunction

    function automatic logic [tofts_pkg::CONF_W-1:0] pick_confidence();
        int unsigned roll = $urandom_range(99);
        if (roll < 6)
            return '0;
        if (roll < 18)
            return tofts_pkg::CONF_W'($urandom);
        if (roll < 28)
            return conf_floor + tofts_pkg::CONF_W'($urandom_range(2)) - tofts_pkg::CONF_W'(1);
        return tofts_pkg::CONF_W'($urandom_range(16'hFFFF, conf_floor));
    endfunction

    function automatic logic [tofts_pkg::CHAN_W-1:0] pick_channel();
        int unsigned roll = $urandom_range(99);
        if (roll < 75)
            return tofts_pkg::CHAN_W'($urandom_range(ZONES, 1));
        if (roll < 85)
            return '0;
        return tofts_pkg::CHAN_W'($urandom_range(255, ZONES + 1));
    endfunction

    // targets past the cap are made the nearest in the window so that
    // counting them would show in the results
    task automatic queue_report(input int unsigned targets, input bit marker_end);
        logic [tofts_pkg::DIST_W-1:0] mm;
        for (int unsigned k = 0; k < targets; k++)
        begin
            if ($urandom_range(99) < 5)
                queue_request(1'b0, tofts_pkg::DIST_W'($urandom),
                              tofts_pkg::CONF_W'($urandom),
                              tofts_pkg::CHAN_W'($urandom), 1'b0);
            mm = (k >= TARGET_CAP) ? ((near_mm == '0) ? tofts_pkg::DIST_W'(1) : near_mm)
                                   : pick_distance();
            queue_request(1'b1, mm, (k >= TARGET_CAP) ? '1 : pick_confidence(),
                          pick_channel(), !marker_end && (k == targets - 1));
        end
        if (marker_end || targets == 0)
            queue_request(1'b0, tofts_pkg::DIST_W'($urandom), tofts_pkg::CONF_W'($urandom),
                          tofts_pkg::CHAN_W'($urandom), 1'b1);
    endtask

    initial
    begin
        int unsigned                 phase;
        int unsigned                 phase_start;
        int unsigned                 roll;
        logic [tofts_pkg::CFG_W-1:0] set_near, set_far, set_conf, set_gain;

        clear_report_state();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty report before anything has been kept
        queue_request(1'b0, '0, '0, '0, 1'b1);
        // one report through the limits at their reset values
        queue_request(1'b1, 16'd100, 16'd50, 8'd1, 1'b0);
        queue_request(1'b1, 16'd100, 16'd60, 8'd1, 1'b0);      // tie, first stays
        queue_request(1'b1, 16'd4999, 16'hFFFF, 8'd9, 1'b0);
        queue_request(1'b1, 16'd300, 16'd40, 8'd0, 1'b0);      // no zone
        queue_request(1'b1, 16'd90, 16'd33, 8'd255, 1'b0);
        queue_request(1'b1, 16'd0, 16'd50, 8'd2, 1'b0);
        queue_request(1'b1, 16'd200, 16'd0, 8'd2, 1'b0);
        queue_request(1'b1, 16'd79, 16'd50, 8'd3, 1'b0);
        queue_request(1'b1, 16'd80, 16'd21, 8'd3, 1'b0);
        queue_request(1'b1, 16'd5000, 16'd25, 8'd4, 1'b0);
        queue_request(1'b1, 16'd5001, 16'd25, 8'd4, 1'b0);
        queue_request(1'b1, 16'd400, 16'd19, 8'd5, 1'b0);
        queue_request(1'b1, 16'd450, 16'd20, 8'd5, 1'b0);
        queue_request(1'b1, 16'hFFFF, 16'hFFFF, 8'd10, 1'b0);
        queue_request(1'b0, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);  // not a target
        queue_request(1'b1, 16'd600, 16'd70, 8'd6, 1'b1);
        // smoothing steps up, then down with a bare end marker
        queue_request(1'b1, 16'd1000, 16'd100, 8'd7, 1'b1);
        queue_request(1'b1, 16'd85, 16'd300, 8'd8, 1'b0);
        queue_request(1'b0, 16'h5555, 16'hAAAA, 8'h55, 1'b1);
        // nothing kept, smoothed value must hold
        queue_request(1'b1, 16'd10, 16'd10, 8'd2, 1'b1);
        wait_for_drain();

        for (phase = 0; phase < 7 || items_queued < TOTAL_ITEMS; phase++)
        begin
            case (phase)
                0:
                begin
                    set_near = tofts_pkg::NEAR_LIMIT_RST;
                    set_far  = tofts_pkg::FAR_LIMIT_RST;
                    set_conf = tofts_pkg::MIN_CONF_RST;
                    set_gain = tofts_pkg::GAIN_RST;
                end
                1:
                begin
                    set_near = '0;
                    set_far  = '1;
                    set_conf = '0;
                    set_gain = '1;
                end
                2:
                begin
                    set_near = '1;
                    set_far  = '1;
                    set_conf = '1;
                    set_gain = '0;
                end
                3:
                begin
                    // window turned inside out: nothing can be kept
                    set_near = 16'd3000;
                    set_far  = 16'd1000;
                    set_conf = 16'd100;
                    set_gain = 16'd30000;
                end
                default:
                begin
                    set_near = tofts_pkg::CFG_W'($urandom_range(2000));
                    set_far  = set_near + tofts_pkg::CFG_W'($urandom_range(6000));
                    set_conf = tofts_pkg::CFG_W'($urandom_range(500));
                    set_gain = tofts_pkg::CFG_W'($urandom);
                end
            endcase
            write_reg(tofts_pkg::REG_NEAR_LIMIT, set_near);
            write_reg(tofts_pkg::REG_FAR_LIMIT, set_far);
            write_reg(tofts_pkg::REG_MIN_CONF, set_conf);
            write_reg(tofts_pkg::REG_GAIN, set_gain);
            steady <= (phase == 4);
            @(negedge clk);

            phase_start = items_queued;
            while (items_queued - phase_start < PHASE_ITEMS)
            begin
                roll = $urandom_range(99);
                if (roll < 8)
                    queue_report(0, 1'b1);
                else if (roll < 14)
                    queue_report($urandom_range(44, TARGET_CAP + 1),
                                 $urandom_range(1) == 1);
                else
                    queue_report($urandom_range(12, 1), $urandom_range(99) < 20);
            end
            wait_for_drain();
        end

        if (error_count == 0)
            $display("[tof_report_target_select] OK");
        else
            $display("[tof_report_target_select] ERROR");
        $finish;
    end

endmodule
